/* hw/rtl/magic_word_length_deframer_macros.svh */
// Assertion macros used by the deframer top level.
`ifndef MAGIC_WORD_LENGTH_DEFRAMER_MACROS_SVH
`define MAGIC_WORD_LENGTH_DEFRAMER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MWLD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deframer assertion failed");

// Next-cycle implication, disabled during reset.
`define MWLD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deframer assertion failed");

`endif

/* hw/rtl/mwld_pkg.sv */
// Shared types and constants for the magic word length deframer.
package mwld_pkg;

   localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd65535;
   localparam int          QUEUE_DEPTH       = 4;

   localparam logic [1:0] KIND_PAYLOAD   = 2'd0;
   localparam logic [1:0] KIND_EMPTY     = 2'd1;
   localparam logic [1:0] KIND_BAD_START = 2'd2;
   localparam logic [1:0] KIND_TOO_LONG  = 2'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data;
      logic        first;
      logic        last;
      logic [31:0] msg_length;
   } entry_type;

endpackage

/* hw/rtl/mwld_front.sv */
// Front end: header collection, header checks and payload byte tagging.
module mwld_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write,
   input  logic [31:0]          csr_wdata,
   input  logic                 byte_accept,
   input  logic [7:0]           rx_byte,
   output logic                 push,
   output mwld_pkg::entry_type  entry
);

   localparam logic [31:0] MAGIC_WORD = 32'h4D41_5852;
   localparam logic [2:0]  LAST_HDR   = 3'd7;

   localparam logic [1:0] PHASE_HEADER  = 2'd0;
   localparam logic [1:0] PHASE_PAYLOAD = 2'd1;
   localparam logic [1:0] PHASE_DEAD    = 2'd2;

   logic [1:0]  phase_ff, phase_in;
   logic [2:0]  count_ff, count_in;
   logic [55:0] hdr_ff, hdr_in;
   logic [31:0] len_ff, len_in;
   logic [31:0] remaining_ff, remaining_in;
   logic        first_ff, first_in;
   logic [31:0] max_payload_ff, max_payload_in;

   always_comb begin
      logic [31:0] word;
      logic [31:0] hdr_len;
      logic        is_last;
      phase_in       = phase_ff;
      count_in       = count_ff;
      hdr_in         = hdr_ff;
      len_in         = len_ff;
      remaining_in   = remaining_ff;
      first_in       = first_ff;
      max_payload_in = csr_write ? csr_wdata : max_payload_ff;
      push           = 1'b0;
      entry          = '0;
      word           = hdr_ff[31:0];
      hdr_len        = {rx_byte, hdr_ff[55:32]};
      is_last        = (remaining_ff <= 32'd1);
      if (byte_accept) begin
         case (phase_ff)
            PHASE_HEADER: begin
               if (count_ff != LAST_HDR) begin
                  hdr_in[8*count_ff +: 8] = rx_byte;
                  count_in = count_ff + 3'd1;
               end else begin
                  count_in         = '0;
                  entry.msg_length = hdr_len;
                  entry.last       = 1'b1;
                  if (word != MAGIC_WORD) begin
                     push       = 1'b1;
                     entry.kind = mwld_pkg::KIND_BAD_START;
                     phase_in   = PHASE_DEAD;
                  end else if (hdr_len > max_payload_ff) begin
                     push       = 1'b1;
                     entry.kind = mwld_pkg::KIND_TOO_LONG;
                     phase_in   = PHASE_DEAD;
                  end else if (hdr_len == 32'd0) begin
                     push        = 1'b1;
                     entry.kind  = mwld_pkg::KIND_EMPTY;
                     entry.first = 1'b1;
                  end else begin
                     remaining_in = hdr_len;
                     len_in       = hdr_len;
                     first_in     = 1'b1;
                     phase_in     = PHASE_PAYLOAD;
                  end
               end
            end
            PHASE_PAYLOAD: begin
               push             = 1'b1;
               entry.kind       = mwld_pkg::KIND_PAYLOAD;
               entry.data       = rx_byte;
               entry.first      = first_ff;
               entry.last       = is_last;
               entry.msg_length = len_ff;
               first_in         = 1'b0;
               if (is_last) begin
                  remaining_in = '0;
                  count_in     = '0;
                  phase_in     = PHASE_HEADER;
               end else begin
                  remaining_in = remaining_ff - 32'd1;
               end
            end
            default: begin
               // dead (and the unused code): drop the byte
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PHASE_HEADER;
         count_ff       <= '0;
         remaining_ff   <= '0;
         first_ff       <= 1'b0;
         max_payload_ff <= mwld_pkg::MAX_PAYLOAD_RESET;
      end else begin
         phase_ff       <= phase_in;
         count_ff       <= count_in;
         remaining_ff   <= remaining_in;
         first_ff       <= first_in;
         max_payload_ff <= max_payload_in;
      end
   end

   always_ff @(posedge clock) begin
      hdr_ff <= hdr_in;
      len_ff <= len_in;
   end

endmodule

/* hw/rtl/mwld_fifo.sv */
// Small register queue between the front end and the output stage.
module mwld_fifo #(
   parameter int DEPTH = mwld_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  mwld_pkg::entry_type  push_entry,
   input  logic                 pop,
   output mwld_pkg::entry_type  head,
   output logic                 empty,
   output logic                 full
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   mwld_pkg::entry_type slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == FULL_CNT);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PW'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + CW'(1);
         2'b01:   count_in = count_ff - CW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* hw/rtl/mwld_back.sv */
// Back end: output register that drains the queue onto the result stream.
module mwld_back (
   input  logic                 clock,
   input  logic                 reset,
   input  mwld_pkg::entry_type  head,
   input  logic                 empty,
   output logic                 pop,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [39:0]          rsp_tdata,
   output logic [2:0]           rsp_tuser,
   output logic                 rsp_tlast
);

   logic                valid_ff, valid_in;
   mwld_pkg::entry_type out_ff, out_in;

   always_comb begin
      pop      = !empty && (!valid_ff || rsp_tready);
      valid_in = valid_ff;
      out_in   = out_ff;
      if (pop) begin
         valid_in = 1'b1;
         out_in   = head;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {out_ff.msg_length, out_ff.data};
   assign rsp_tuser  = {out_ff.first, out_ff.kind};
   assign rsp_tlast  = out_ff.last;

endmodule

/* hw/rtl/magic_word_length_deframer.sv */
// Each result is a queue entry and leaves on rsp through the output register.
// Throughput: one byte per cycle; req_tready drops only when the result queue is full.
// Dropped bytes give no result; a header gives one only if empty, bad or too long.
// Reset (synchronous, active high) returns to header collection, clears the dead
// state and the queue, and sets max_payload to 65535. No clearing pass.
`include "magic_word_length_deframer_macros.svh"

module magic_word_length_deframer #(
   parameter int QUEUE_DEPTH = mwld_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   // configuration: max_payload
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_wdata,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [7:0] data, [39:8] msg_length
   output logic [2:0]  rsp_tuser,   // [1:0] kind, [2] first
   output logic        rsp_tlast
);

   logic                q_push;
   logic                q_pop;
   logic                q_empty;
   logic                q_full;
   logic                byte_accept;
   mwld_pkg::entry_type q_entry;
   mwld_pkg::entry_type q_head;

   assign csr_ready   = 1'b1;
   assign req_tready  = !q_full;
   assign byte_accept = req_tvalid && req_tready;

   mwld_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_valid),
      .csr_wdata   (csr_wdata),
      .byte_accept (byte_accept),
      .rx_byte     (req_tdata),
      .push        (q_push),
      .entry       (q_entry)
   );

   mwld_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .head       (q_head),
      .empty      (q_empty),
      .full       (q_full)
   );

   mwld_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (q_head),
      .empty      (q_empty),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // a push never lands on a full queue
   `MWLD_ASSERT_IMPL(a_no_overflow, clock, reset, q_push, !q_full)
   // after an error entry the front end goes quiet
   `MWLD_ASSERT_NEXT(a_dead_after_error, clock, reset, q_push && q_entry.kind[1], !q_push)
   // every result that is not a payload byte closes its message
   `MWLD_ASSERT_IMPL(a_nonpayload_last, clock, reset,
      rsp_tvalid && (rsp_tuser[1:0] != mwld_pkg::KIND_PAYLOAD), rsp_tlast)

endmodule
